>>> design/pcgr_pkg.sv
// Shared types, constants and draw function for the PCG32 range generator.
`default_nettype none
package pcgr_pkg;

    localparam logic [63:0] LCG_MULT  = 64'd6364136223846793005;
    localparam logic [63:0] LCG_INC   = 64'd1442695040888963407;
    localparam logic [63:0] LCG_RESET = LCG_INC * LCG_MULT + LCG_INC;

    localparam int unsigned XSH_SHIFT   = 18;
    localparam int unsigned XSH_DROP    = 27;
    localparam int unsigned ROT_LSB     = 59;
    localparam int unsigned FRAC_DROP   = 11;
    localparam int unsigned DIV_STEPS   = 64;

    typedef enum logic [2:0] {
        REQ_RAW64  = 3'd0,
        REQ_RANGE  = 3'd1,
        REQ_CHANCE = 3'd2,
        REQ_REAL   = 3'd3,
        REQ_RESEED = 3'd4
    } req_kind_t;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LO,
        PH_CROSS1,
        PH_CROSS2
    } lcg_phase_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_TGO,
        S_TWAIT,
        S_DRAW,
        S_DWAIT,
        S_CHECK,
        S_MGO,
        S_MWAIT,
        S_SEED,
        S_SADV,
        S_SWAIT,
        S_RESP
    } seq_state_t;

    typedef struct packed {
        logic advance;
        logic load;
    } lcg_cmd_t;

    function automatic logic [31:0] draw32(input logic [63:0] s);
        logic [63:0] mix;
        logic [31:0] x;
        logic [4:0]  r;
        logic [63:0] xx;
        mix = ((s >> XSH_SHIFT) ^ s) >> XSH_DROP;
        x   = mix[31:0];
        r   = s[63:59];
        xx  = {x, x} >> r;
        return xx[31:0];
    endfunction

endpackage
`default_nettype wire

>>> design/pcgr_if.sv
// Request and response channel interfaces for the PCG32 range generator.
`default_nettype none
interface pcgr_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         req_type;
    logic signed [31:0] range_min;
    logic signed [31:0] range_max;
    logic [31:0]        chance_n;

    modport source (output valid, output req_type, output range_min, output range_max,
                    output chance_n, input ready);
    modport sink (input valid, input req_type, input range_min, input range_max,
                  input chance_n, output ready);
endinterface

interface pcgr_rsp_if;
    logic               valid;
    logic               ready;
    logic [63:0]        random_bits;
    logic signed [31:0] range_value;
    logic               chance_hit;
    logic               bad_request;

    modport source (output valid, output random_bits, output range_value,
                    output chance_hit, output bad_request, input ready);
    modport sink (input valid, input random_bits, input range_value,
                  input chance_hit, input bad_request, output ready);
endinterface
`default_nettype wire

>>> design/pcgr_lcg.sv
// LCG state register with a shared 32x32 multiplier stepping the 64-bit advance.
`default_nettype none
module pcgr_lcg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pcgr_pkg::lcg_cmd_t cmd,
    input  wire logic [63:0]       seed,
    output logic [63:0]            state,
    output logic                   done
);

    pcgr_pkg::lcg_phase_t phase_reg, phase_next;
    logic [63:0] lcg_state_reg, lcg_state_next;
    logic [63:0] prod_reg, prod_next;
    logic [63:0] acc_reg, acc_next;
    logic [31:0] mul_a, mul_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= pcgr_pkg::PH_IDLE;
            lcg_state_reg <= pcgr_pkg::LCG_RESET;
        end
        else
        begin
            phase_reg     <= phase_next;
            lcg_state_reg <= lcg_state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
    end

    always_comb
    begin
        phase_next     = phase_reg;
        lcg_state_next = lcg_state_reg;
        acc_next       = acc_reg;
        done           = 1'b0;
        mul_a          = lcg_state_reg[31:0];
        mul_b          = pcgr_pkg::LCG_MULT[31:0];
        case (phase_reg)
            pcgr_pkg::PH_IDLE:
            begin
                if (cmd.load)
                begin
                    lcg_state_next = pcgr_pkg::LCG_INC + seed;
                end
                else if (cmd.advance)
                begin
                    phase_next = pcgr_pkg::PH_LO;
                end
            end
            pcgr_pkg::PH_LO:
            begin
                mul_b      = pcgr_pkg::LCG_MULT[63:32];
                acc_next   = prod_reg + pcgr_pkg::LCG_INC;
                phase_next = pcgr_pkg::PH_CROSS1;
            end
            pcgr_pkg::PH_CROSS1:
            begin
                mul_a      = lcg_state_reg[63:32];
                acc_next   = {acc_reg[63:32] + prod_reg[31:0], acc_reg[31:0]};
                phase_next = pcgr_pkg::PH_CROSS2;
            end
            pcgr_pkg::PH_CROSS2:
            begin
                lcg_state_next = {acc_reg[63:32] + prod_reg[31:0], acc_reg[31:0]};
                phase_next     = pcgr_pkg::PH_IDLE;
                done           = 1'b1;
            end
            default:
            begin
                phase_next = pcgr_pkg::PH_IDLE;
            end
        endcase
        prod_next = mul_a * mul_b;
    end

    assign state = lcg_state_reg;

endmodule
`default_nettype wire

>>> design/pcgr_divider.sv
// Restoring remainder unit: 64-bit dividend by 33-bit divisor, one bit per cycle.
`default_nettype none
module pcgr_divider (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [32:0] divisor,
    output logic [32:0]      remainder,
    output logic             done
);

    logic        running_reg, running_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] quot_reg, quot_next;
    logic [32:0] rem_reg, rem_next;
    logic [32:0] dvsr_reg, dvsr_next;
    logic [33:0] shifted;
    logic [33:0] diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= 1'b0;
            done_reg    <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            running_reg <= running_next;
            done_reg    <= done_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
    end

    always_comb
    begin
        running_next = running_reg;
        done_next    = 1'b0;
        cnt_next     = cnt_reg;
        quot_next    = quot_reg;
        rem_next     = rem_reg;
        dvsr_next    = dvsr_reg;
        shifted      = {rem_reg, quot_reg[63]};
        diff         = shifted - {1'b0, dvsr_reg};
        if (start)
        begin
            running_next = 1'b1;
            cnt_next     = '0;
            quot_next    = dividend;
            rem_next     = '0;
            dvsr_next    = divisor;
        end
        else if (running_reg)
        begin
            quot_next = {quot_reg[62:0], 1'b0};
            rem_next  = diff[33] ? shifted[32:0] : diff[32:0];
            cnt_next  = cnt_reg + 6'd1;
            if (cnt_reg == 6'(pcgr_pkg::DIV_STEPS - 1))
            begin
                running_next = 1'b0;
                done_next    = 1'b1;
            end
        end
    end

    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule
`default_nettype wire

>>> design/pcg32_uniform_range_generator.sv
// Top level: request sequencer of the PCG32 uniform range generator.
//
//  channel | dir | handshake     | payload
//  req     | in  | valid/ready   | req_type, range_min, range_max, chance_n
//  rsp     | out | valid/ready   | random_bits, range_value, chance_hit, bad_request
//  cfg     | in  | cfg_we        | cfg_wdata (seed_value)
//
// One request at a time; req.ready is high only while the sequencer is idle.
// Raw and fraction requests take two LCG advances on the shared 32x32
// multiplier. Range and chance requests add two passes of the remainder
// unit, plus two advances per redraw. Reseed loads and advances once;
// errors respond at once. Reset loads the state seeded with zero at once.
// The result holds in its register until rsp.ready; no new request meanwhile.
`default_nettype none
module pcg32_uniform_range_generator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [63:0] cfg_wdata,
    pcgr_req_if.sink         req,
    pcgr_rsp_if.source       rsp
);

    pcgr_pkg::seq_state_t state_reg, state_next;
    pcgr_pkg::req_kind_t  kind_reg, kind_next;
    logic [63:0] seed_value_reg;
    logic        half_reg, half_next;
    logic [32:0] span_reg, span_next;
    logic [32:0] thresh_reg, thresh_next;
    logic [31:0] min_reg, min_next;
    logic [63:0] draw_reg, draw_next;
    logic [63:0] bits_reg, bits_next;
    logic [31:0] rval_reg, rval_next;
    logic        hit_reg, hit_next;
    logic        bad_reg, bad_next;

    pcgr_pkg::lcg_cmd_t lcg_cmd;
    logic [63:0] lcg_state;
    logic        lcg_done;
    logic        div_start;
    logic [63:0] div_dividend;
    logic [32:0] div_rem;
    logic        div_done;
    logic [32:0] span_calc;

    pcgr_lcg u_lcg (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (lcg_cmd),
        .seed  (seed_value_reg),
        .state (lcg_state),
        .done  (lcg_done)
    );

    pcgr_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (span_reg),
        .remainder (div_rem),
        .done      (div_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pcgr_pkg::S_IDLE;
            seed_value_reg <= '0;
            half_reg       <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            half_reg  <= half_next;
            if (cfg_we)
            begin
                seed_value_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        span_reg   <= span_next;
        thresh_reg <= thresh_next;
        min_reg    <= min_next;
        draw_reg   <= draw_next;
        bits_reg   <= bits_next;
        rval_reg   <= rval_next;
        hit_reg    <= hit_next;
        bad_reg    <= bad_next;
    end

    assign span_calc = {req.range_max[31], req.range_max}
                     - {req.range_min[31], req.range_min} + 33'd1;

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        half_next       = half_reg;
        span_next       = span_reg;
        thresh_next     = thresh_reg;
        min_next        = min_reg;
        draw_next       = draw_reg;
        bits_next       = bits_reg;
        rval_next       = rval_reg;
        hit_next        = hit_reg;
        bad_next        = bad_reg;
        lcg_cmd.advance = 1'b0;
        lcg_cmd.load    = 1'b0;
        div_start       = 1'b0;
        div_dividend    = 64'd0 - {31'd0, span_reg};
        req.ready       = 1'b0;
        rsp.valid       = 1'b0;
        case (state_reg)
            pcgr_pkg::S_IDLE:
            begin
                req.ready = 1'b1;
                if (req.valid)
                begin
                    bits_next = '0;
                    rval_next = '0;
                    hit_next  = 1'b0;
                    bad_next  = 1'b0;
                    half_next = 1'b0;
                    min_next  = req.range_min;
                    case (req.req_type)
                        pcgr_pkg::REQ_RAW64, pcgr_pkg::REQ_REAL:
                        begin
                            kind_next  = pcgr_pkg::req_kind_t'(req.req_type);
                            state_next = pcgr_pkg::S_DRAW;
                        end
                        pcgr_pkg::REQ_RANGE:
                        begin
                            kind_next = pcgr_pkg::REQ_RANGE;
                            span_next = span_calc;
                            if (req.range_max < req.range_min)
                            begin
                                rval_next  = req.range_min;
                                bad_next   = 1'b1;
                                state_next = pcgr_pkg::S_RESP;
                            end
                            else
                            begin
                                state_next = pcgr_pkg::S_TGO;
                            end
                        end
                        pcgr_pkg::REQ_CHANCE:
                        begin
                            kind_next = pcgr_pkg::REQ_CHANCE;
                            span_next = {1'b0, req.chance_n};
                            if (req.chance_n == 32'd0)
                            begin
                                bad_next   = 1'b1;
                                state_next = pcgr_pkg::S_RESP;
                            end
                            else
                            begin
                                state_next = pcgr_pkg::S_TGO;
                            end
                        end
                        pcgr_pkg::REQ_RESEED:
                        begin
                            kind_next  = pcgr_pkg::REQ_RESEED;
                            state_next = pcgr_pkg::S_SEED;
                        end
                        default:
                        begin
                            bad_next   = 1'b1;
                            state_next = pcgr_pkg::S_RESP;
                        end
                    endcase
                end
            end
            pcgr_pkg::S_TGO:
            begin
                div_start  = 1'b1;
                state_next = pcgr_pkg::S_TWAIT;
            end
            pcgr_pkg::S_TWAIT:
            begin
                if (div_done)
                begin
                    thresh_next = div_rem;
                    state_next  = pcgr_pkg::S_DRAW;
                end
            end
            pcgr_pkg::S_DRAW:
            begin
                lcg_cmd.advance = 1'b1;
                draw_next       = {draw_reg[31:0], pcgr_pkg::draw32(lcg_state)};
                state_next      = pcgr_pkg::S_DWAIT;
            end
            pcgr_pkg::S_DWAIT:
            begin
                if (lcg_done)
                begin
                    half_next  = ~half_reg;
                    state_next = half_reg ? pcgr_pkg::S_CHECK : pcgr_pkg::S_DRAW;
                end
            end
            pcgr_pkg::S_CHECK:
            begin
                case (kind_reg)
                    pcgr_pkg::REQ_RAW64:
                    begin
                        bits_next  = draw_reg;
                        state_next = pcgr_pkg::S_RESP;
                    end
                    pcgr_pkg::REQ_REAL:
                    begin
                        bits_next  = draw_reg >> pcgr_pkg::FRAC_DROP;
                        state_next = pcgr_pkg::S_RESP;
                    end
                    default:
                    begin
                        if (draw_reg < {31'd0, thresh_reg})
                        begin
                            state_next = pcgr_pkg::S_DRAW;
                        end
                        else
                        begin
                            state_next = pcgr_pkg::S_MGO;
                        end
                    end
                endcase
            end
            pcgr_pkg::S_MGO:
            begin
                div_start    = 1'b1;
                div_dividend = draw_reg;
                state_next   = pcgr_pkg::S_MWAIT;
            end
            pcgr_pkg::S_MWAIT:
            begin
                if (div_done)
                begin
                    if (kind_reg == pcgr_pkg::REQ_RANGE)
                    begin
                        rval_next = min_reg + div_rem[31:0];
                    end
                    else
                    begin
                        hit_next = (div_rem == 33'd0);
                    end
                    state_next = pcgr_pkg::S_RESP;
                end
            end
            pcgr_pkg::S_SEED:
            begin
                lcg_cmd.load = 1'b1;
                state_next   = pcgr_pkg::S_SADV;
            end
            pcgr_pkg::S_SADV:
            begin
                lcg_cmd.advance = 1'b1;
                state_next      = pcgr_pkg::S_SWAIT;
            end
            pcgr_pkg::S_SWAIT:
            begin
                if (lcg_done)
                begin
                    state_next = pcgr_pkg::S_RESP;
                end
            end
            pcgr_pkg::S_RESP:
            begin
                rsp.valid = 1'b1;
                if (rsp.ready)
                begin
                    state_next = pcgr_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = pcgr_pkg::S_IDLE;
            end
        endcase
    end

    assign rsp.random_bits = bits_reg;
    assign rsp.range_value = rval_reg;
    assign rsp.chance_hit  = hit_reg;
    assign rsp.bad_request = bad_reg;

endmodule
`default_nettype wire
